>>> hdl/hprm_pkg.sv
// hprm_pkg: shared types and constants of the hall period rpm meter
// no dependencies; imported by hprm_div, hall_period_rpm_meter_unit and the testbench

package hprm_pkg;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned ADDR_W = 3;

	localparam logic REG_FILTER    = 1'b0;
	localparam logic REG_NUMERATOR = 1'b1;

	localparam logic              FILTER_RESET    = 1'b1;
	localparam logic [DATA_W-1:0] NUMERATOR_RESET = 32'd20000000;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_AVG_GO,
		ST_AVG_RUN,
		ST_RPM_GO,
		ST_RPM_RUN,
		ST_DONE
	} state_t;

endpackage

>>> hdl/hprm_div.sv
// hprm_div: bit-serial restoring divider, one quotient bit per cycle
// depends on hprm_pkg for the divisor width

module hprm_div import hprm_pkg::*; #(
	parameter int unsigned DW = 34
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DW-1:0]     dividend,
	input  logic [DATA_W-1:0] divisor,
	output logic              done,
	output logic [DW-1:0]     quotient
);

	localparam int unsigned CW = $clog2(DW + 1);

	logic [DATA_W:0]   rem_q;
	logic [DW-1:0]     num_q;
	logic [DATA_W-1:0] div_q;
	logic [CW-1:0]     cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [DATA_W:0]   trial;
	logic [DATA_W+1:0] diff;
	logic              ge;

	always_comb begin
		trial = {rem_q[DATA_W-1:0], num_q[DW-1]};
		diff  = {1'b0, trial} - {2'b00, div_q};
		ge    = ~diff[DATA_W+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			num_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DATA_W:0] : trial;
			num_q <= {num_q[DW-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = num_q;

endmodule

>>> hdl/hall_period_rpm_meter_unit.sv
// hall_period_rpm_meter_unit: hall sensor period meter with ring average and rpm
// depends on hprm_pkg and hprm_div
//
// sample channel (sample_valid/sample_ready) takes a hall level and a microsecond
// timestamp; a falling edge closes a period, which enters a ring of RING_DEPTH
// periods with a running sum. every request gives one result on the result
// channel (result_valid/result_ready): edge_seen, reported_period (ring average
// or latest period per filter_enable) and rpm = rpm_numerator / average (0
// when the average is zero). the average and the rpm come from one shared
// bit-serial divider of SUM_W = 32 + clog2(RING_DEPTH) steps, used for the
// average and then, when the average is nonzero, for the rpm. one request
// is in work at a time; the next is accepted while the previous result still
// waits in the output register, and a stalled receiver holds the finished
// result in the done state until the output register frees up.
// reset clears the ring, sum and timing state, sets the previous level high,
// filter_enable to 1 and rpm_numerator to 20000000. configuration by apb:
// filter_enable at 0x0, rpm_numerator at 0x4.

module hall_period_rpm_meter_unit import hprm_pkg::*; #(
	parameter int unsigned RING_DEPTH = 3
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	input  logic              sample_valid,
	output logic              sample_ready,
	input  logic              hall_level,
	input  logic [DATA_W-1:0] timestamp_us,
	output logic              result_valid,
	input  logic              result_ready,
	output logic              edge_seen,
	output logic [DATA_W-1:0] reported_period,
	output logic [DATA_W-1:0] rpm
);

	localparam int unsigned SUM_W = DATA_W + $clog2(RING_DEPTH);

	state_t state_q, state_d;

	logic              filter_q;
	logic [DATA_W-1:0] numer_q;
	logic              prev_q;
	logic [DATA_W-1:0] start_time_q;
	logic [DATA_W-1:0] latest_q;
	logic [DATA_W-1:0] ring_q [RING_DEPTH];
	logic [SUM_W-1:0]  sum_q;
	logic              edge_q;
	logic [DATA_W-1:0] avg_q;
	logic [DATA_W-1:0] rpm_q;
	logic              result_valid_q;
	logic              edge_out_q;
	logic [DATA_W-1:0] reported_q;
	logic [DATA_W-1:0] rpm_out_q;

	logic              accept;
	logic              fall;
	logic [DATA_W-1:0] period;
	logic              div_start;
	logic [SUM_W-1:0]  div_dividend;
	logic [DATA_W-1:0] div_divisor;
	logic              div_done;
	logic [SUM_W-1:0]  div_quot;
	logic              load_out;
	logic              cfg_wr;

	hprm_div #(
		.DW(SUM_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quot)
	);

	// configuration
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_q <= FILTER_RESET;
			numer_q  <= NUMERATOR_RESET;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_FILTER) begin
				filter_q <= pwdata[0];
			end else begin
				numer_q <= pwdata;
			end
		end
	end

	assign prdata = (paddr[2] == REG_NUMERATOR) ? numer_q : {{(DATA_W-1){1'b0}}, filter_q};

	// sample intake and ring
	assign sample_ready = (state_q == ST_IDLE);
	assign accept       = sample_valid & sample_ready;
	assign fall         = prev_q & ~hall_level;
	assign period       = timestamp_us - start_time_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q       <= 1'b1;
			start_time_q <= '0;
			latest_q     <= '0;
			sum_q        <= '0;
			edge_q       <= 1'b0;
			for (int i = 0; i < RING_DEPTH; i++) begin
				ring_q[i] <= '0;
			end
		end else if (accept) begin
			prev_q <= hall_level;
			edge_q <= fall;
			if (fall) begin
				start_time_q <= timestamp_us;
				latest_q     <= period;
				sum_q        <= sum_q - SUM_W'(ring_q[RING_DEPTH-1]) + SUM_W'(period);
				ring_q[0]    <= period;
				for (int i = 1; i < RING_DEPTH; i++) begin
					ring_q[i] <= ring_q[i-1];
				end
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		div_start    = 1'b0;
		div_dividend = sum_q;
		div_divisor  = DATA_W'(RING_DEPTH);
		load_out     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_AVG_GO;
				end
			end
			ST_AVG_GO: begin
				div_start = 1'b1;
				state_d   = ST_AVG_RUN;
			end
			ST_AVG_RUN: begin
				if (div_done) begin
					state_d = (div_quot[DATA_W-1:0] == '0) ? ST_DONE : ST_RPM_GO;
				end
			end
			ST_RPM_GO: begin
				div_start    = 1'b1;
				div_dividend = SUM_W'(numer_q);
				div_divisor  = avg_q;
				state_d      = ST_RPM_RUN;
			end
			ST_RPM_RUN: begin
				if (div_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!result_valid_q || result_ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// division results
	always_ff @(posedge clk) begin
		if (state_q == ST_AVG_RUN && div_done) begin
			avg_q <= div_quot[DATA_W-1:0];
			rpm_q <= '0;
		end else if (state_q == ST_RPM_RUN && div_done) begin
			rpm_q <= div_quot[DATA_W-1:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (load_out) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			edge_out_q <= edge_q;
			reported_q <= filter_q ? avg_q : latest_q;
			rpm_out_q  <= rpm_q;
		end
	end

	assign result_valid    = result_valid_q;
	assign edge_seen       = edge_out_q;
	assign reported_period = reported_q;
	assign rpm             = rpm_out_q;

endmodule

>>> verif/hall_period_rpm_meter_unit_tb.sv
// hall_period_rpm_meter_unit_tb: self-checking testbench for the hall period rpm meter
// drives sample requests and apb register writes, predicts every result in a scoreboard
// depends on hprm_pkg and the hall_period_rpm_meter_unit rtl

localparam int unsigned METER_RING_DEPTH = 3;

typedef struct packed {
	logic        edge_seen;
	logic [31:0] period;
	logic [31:0] rpm;
} meter_result_t;

class rpm_scoreboard;
	bit            filter_on;
	bit [31:0]     numerator;
	bit            prev_level;
	bit [31:0]     edge_start;
	bit [31:0]     ring [METER_RING_DEPTH];
	int unsigned   wr_idx;
	bit [31:0]     latest;
	meter_result_t expected_q[$];
	int unsigned   fail_count;

	function new();
		filter_on  = hprm_pkg::FILTER_RESET;
		numerator  = hprm_pkg::NUMERATOR_RESET;
		prev_level = 1'b1;
		edge_start = '0;
		foreach (ring[i]) ring[i] = '0;
		wr_idx     = 0;
		latest     = '0;
		fail_count = 0;
	endfunction

	function void note_sample(bit level, bit [31:0] ts);
		bit [63:0]     sum;
		bit [31:0]     avg;
		meter_result_t res;
		res.edge_seen = 1'b0;
		if (prev_level && !level) begin
			ring[wr_idx] = ts - edge_start;
			latest       = ts - edge_start;
			wr_idx       = (wr_idx + 1) % METER_RING_DEPTH;
			edge_start   = ts;
			res.edge_seen = 1'b1;
		end
		prev_level = level;
		sum = '0;
		foreach (ring[i]) sum += {32'b0, ring[i]};
		avg = 32'(sum / METER_RING_DEPTH);
		res.rpm    = (avg == 0) ? 32'd0 : numerator / avg;
		res.period = filter_on ? avg : latest;
		expected_q.push_back(res);
	endfunction

	function void check_result(bit e, bit [31:0] p, bit [31:0] r);
		meter_result_t exp_res;
		if (expected_q.size() == 0) begin
			$error("result with no request pending");
			fail_count++;
			return;
		end
		exp_res = expected_q.pop_front();
		if (e !== exp_res.edge_seen) begin
			$error("edge_seen mismatch: expected %0d, actual %0d", exp_res.edge_seen, e);
			fail_count++;
		end
		if (p !== exp_res.period) begin
			$error("reported_period mismatch: expected %0d, actual %0d", exp_res.period, p);
			fail_count++;
		end
		if (r !== exp_res.rpm) begin
			$error("rpm mismatch: expected %0d, actual %0d", exp_res.rpm, r);
			fail_count++;
		end
	endfunction

	function int unsigned pending();
		return expected_q.size();
	endfunction
endclass

module hall_period_rpm_meter_unit_tb;
	import hprm_pkg::*;

	localparam logic [ADDR_W-1:0] ADDR_FILTER    = ADDR_W'(4 * REG_FILTER);
	localparam logic [ADDR_W-1:0] ADDR_NUMERATOR = ADDR_W'(4 * REG_NUMERATOR);
	localparam int unsigned       RUN_LIMIT      = 4000000;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              sample_valid;
	logic              sample_ready;
	logic              hall_level;
	logic [DATA_W-1:0] timestamp_us;
	logic              result_valid;
	logic              result_ready;
	logic              edge_seen;
	logic [DATA_W-1:0] reported_period;
	logic [DATA_W-1:0] rpm;

	rpm_scoreboard sb = new();

	int unsigned tx_idle_pct;
	int unsigned rx_stall_pct;
	int unsigned rx_hold_req;
	logic [31:0] cur_ts;
	logic        last_level;

	hall_period_rpm_meter_unit #(
		.RING_DEPTH(METER_RING_DEPTH)
	) u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.sample_valid   (sample_valid),
		.sample_ready   (sample_ready),
		.hall_level     (hall_level),
		.timestamp_us   (timestamp_us),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.edge_seen      (edge_seen),
		.reported_period(reported_period),
		.rpm            (rpm)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	initial begin
		#(RUN_LIMIT);
		$display("CHECK FAILED");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && result_ready)
				sb.check_result(edge_seen, reported_period, rpm);
			if (sample_valid && sample_ready)
				sb.note_sample(hall_level, timestamp_us);
		end
	end

	// receiver with random stalls and a long hold-off on request
	initial begin
		int unsigned hold_left;
		hold_left = 0;
		result_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold_req != 0) begin
				hold_left   = rx_hold_req;
				rx_hold_req = 0;
			end
			if (hold_left != 0) begin
				result_ready <= 1'b0;
				hold_left--;
			end else begin
				result_ready <= ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic set_filter(input bit f);
		apb_write(ADDR_FILTER, {31'b0, f});
		sb.filter_on = f;
	endtask

	task automatic set_numerator(input logic [31:0] n);
		apb_write(ADDR_NUMERATOR, n);
		sb.numerator = n;
	endtask

	task automatic send_sample(input logic lvl, input logic [31:0] ts);
		while ($urandom_range(99) < tx_idle_pct) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		hall_level   <= lvl;
		timestamp_us <= ts;
		do @(posedge clk); while (!sample_ready);
	endtask

	task automatic drain();
		sample_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_half_period();
		int unsigned s;
		s = $urandom_range(99);
		if (s < 40)
			return $urandom_range(64, 1);
		else if (s < 75)
			return $urandom_range(200000, 100);
		else if (s < 90)
			return $urandom_range(3, 0);
		return $urandom;
	endfunction

	// mostly alternating levels with advancing time, some repeats and some noise
	task automatic send_random(input int unsigned n);
		int unsigned r;
		logic        lvl;
		for (int unsigned i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 80) begin
				lvl    = ~last_level;
				cur_ts = cur_ts + pick_half_period();
			end else if (r < 90) begin
				lvl    = last_level;
				cur_ts = cur_ts + $urandom_range(1000, 0);
			end else begin
				lvl    = 1'($urandom_range(1, 0));
				cur_ts = $urandom;
			end
			send_sample(lvl, cur_ts);
			last_level = lvl;
		end
	endtask

	initial begin
		int unsigned wait_cycles;
		arst_n       <= 1'b0;
		psel         <= 1'b0;
		penable      <= 1'b0;
		pwrite       <= 1'b0;
		paddr        <= '0;
		pwdata       <= '0;
		sample_valid <= 1'b0;
		hall_level   <= 1'b1;
		timestamp_us <= '0;
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		rx_hold_req  = 0;
		cur_ts       = '0;
		last_level   = 1'b1;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: zero average, first edge from time 0, wrap, huge periods
		send_sample(1'b1, 32'd100);
		send_sample(1'b0, 32'd1000);
		send_sample(1'b0, 32'd1200);
		send_sample(1'b1, 32'd2000);
		send_sample(1'b0, 32'd3000);
		send_sample(1'b1, 32'd4000);
		send_sample(1'b0, 32'd6000);
		send_sample(1'b1, 32'hFFFF_FF00);
		send_sample(1'b0, 32'h0000_0100);
		send_sample(1'b1, 32'h7FFF_FFFF);
		send_sample(1'b0, 32'hFFFF_FFFF);
		drain();

		// raw period reporting, zero numerator, shortest periods
		set_filter(1'b0);
		set_numerator(32'd0);
		send_sample(1'b1, 32'd10);
		send_sample(1'b0, 32'd11);
		send_sample(1'b1, 32'd11);
		send_sample(1'b0, 32'd12);
		send_sample(1'b1, 32'd12);
		send_sample(1'b0, 32'd13);
		send_sample(1'b1, 32'd13);
		send_sample(1'b0, 32'd14);
		drain();
		set_numerator(32'hFFFF_FFFF);
		send_sample(1'b1, 32'd14);
		send_sample(1'b0, 32'd15);
		send_sample(1'b1, 32'd15);
		send_sample(1'b0, 32'd15);
		drain();
		cur_ts     = 32'd15;
		last_level = 1'b0;

		set_filter(1'b1);
		set_numerator(NUMERATOR_RESET);
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		send_random(300);
		drain();

		set_filter(1'b0);
		set_numerator(32'd1);
		tx_idle_pct  = 86;
		rx_stall_pct = 0;
		send_random(300);
		drain();

		set_filter(1'b1);
		set_numerator(32'hFFFF_FFFF);
		tx_idle_pct  = 0;
		rx_stall_pct = 86;
		send_random(300);
		drain();

		set_filter(1'b0);
		set_numerator($urandom);
		tx_idle_pct  = 10;
		rx_stall_pct = 10;
		send_random(200);
		drain();

		// long receiver hold-off while requests keep coming
		set_filter(1'b1);
		set_numerator($urandom_range(100000000, 1));
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		rx_hold_req  = 800;
		send_random(50);
		sample_valid <= 1'b0;

		wait_cycles = 0;
		while (sb.pending() != 0 && wait_cycles < 20000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (200) @(posedge clk);
		if (sb.pending() != 0)
			$error("%0d expected results never arrived", sb.pending());
		if (sb.fail_count == 0 && sb.pending() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
